// ===== rtl/tgfsr_pkg.sv =====
// ----------------------------------------------------------------------------
// tgfsr_pkg
// shared types, constants, the ring start words and the tempering function
// of the tgfsr word generator
// ----------------------------------------------------------------------------
package tgfsr_pkg;

   localparam int WORDS      = 25;
   localparam int WORD_BITS  = 32;
   localparam int LAG_START  = 6;

   // the state is kept as a ring rotated so that the lead word sits at tap 1;
   // the lag pointer always runs LAG_START + 1 slots ahead of the lead
   localparam int LEAD_TAP   = 1;
   localparam int LAG_TAP    = LEAD_TAP + LAG_START + 1;

   localparam logic [WORD_BITS-1:0] TWIST  = 32'h8EBF_D028;
   localparam logic [WORD_BITS-1:0] MASK_B = 32'h2B5B_2500;
   localparam logic [WORD_BITS-1:0] MASK_C = 32'hDB8B_0000;
   localparam int SHIFT_S = 7;
   localparam int SHIFT_T = 15;
   localparam int SHIFT_L = 16;

   localparam logic [WORD_BITS-1:0] BASE_WORDS [WORDS] = '{
      32'h95F24DAB, 32'h0B685215, 32'hE76CCAE7, 32'hAF3EC239, 32'h715FAD23,
      32'h24A590AD, 32'h69E4B5EF, 32'hBF456141, 32'h96BC1B7B, 32'hA7BDF825,
      32'hC1DE75B7, 32'h8858A9C9, 32'h2DA87693, 32'hB657F9DD, 32'hFFDC8A9F,
      32'h8121DA71, 32'h8B823ECB, 32'h885D05F5, 32'h4E20CD47, 32'h5A9AD5D9,
      32'h512C0C03, 32'hEA857CCD, 32'h4CC1D30F, 32'h8891A8A1, 32'hA6B7AADB
   };

   typedef enum logic {
      MODE_SEED = 1'b0,
      MODE_NEXT = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [WORD_BITS-1:0] seed;
   } cmd_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   // ring tap k after a reseed holds the table word of slot (k - 1) mod WORDS xor the seed
   function automatic logic [WORD_BITS-1:0] ring_start_word(input int k);
      logic [WORD_BITS-1:0] w;
      if (k == 0) begin
         w = BASE_WORDS[WORDS-1];
      end else begin
         w = BASE_WORDS[k-1];
      end
      return w;
   endfunction

   function automatic logic [WORD_BITS-1:0] temper(input logic [WORD_BITS-1:0] y);
      logic [WORD_BITS-1:0] v;
      v = y ^ ((y << SHIFT_S) & MASK_B);
      v = v ^ ((v << SHIFT_T) & MASK_C);
      v = v ^ (v >> SHIFT_L);
      return v;
   endfunction

endpackage

// ===== rtl/tgfsr_front.sv =====
// ----------------------------------------------------------------------------
// tgfsr_front
// input register stage: takes request beats, classifies them and pushes
// them into the command queue
// ----------------------------------------------------------------------------
module tgfsr_front import tgfsr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic [WORD_BITS-1:0] req_seed,
   input  logic                 q_full,
   output logic                 push,
   output cmd_type              push_cmd
);

   logic    front_valid_ff, front_valid_in;
   cmd_type front_cmd_ff, front_cmd_in;
   logic    take;

   assign push      = front_valid_ff && !q_full;
   assign req_stall = front_valid_ff && q_full;
   assign take      = req_valid && !req_stall;
   assign push_cmd  = front_cmd_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      front_cmd_in   = front_cmd_ff;
      if (push) begin
         front_valid_in = 1'b0;
      end
      if (take) begin
         front_valid_in    = 1'b1;
         front_cmd_in.mode = req_mode ? MODE_NEXT : MODE_SEED;
         // seed only matters for a reseed
         front_cmd_in.seed = req_mode ? '0 : req_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_cmd_ff <= front_cmd_in;
   end

endmodule

// ===== rtl/tgfsr_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// tgfsr_cmd_queue
// two-entry command queue between front and back end
// ----------------------------------------------------------------------------
module tgfsr_cmd_queue import tgfsr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   input  logic     pop,
   output logic     q_full,
   output head_type head
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_full     = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/tgfsr_back.sv =====
// ----------------------------------------------------------------------------
// tgfsr_back
// back end: rotating state ring, twist step, tempering and result register
// ----------------------------------------------------------------------------
module tgfsr_back import tgfsr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  head_type             head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_value
);

   logic [WORD_BITS-1:0] ring_ff [WORDS];
   logic [WORD_BITS-1:0] ring_in [WORDS];
   logic                 out_valid_ff, out_valid_in;
   logic [WORD_BITS-1:0] out_value_ff, out_value_in;
   logic [WORD_BITS-1:0] lead_word;
   logic [WORD_BITS-1:0] y;
   logic                 out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign pop       = head.valid && ((head.cmd.mode == MODE_SEED) || out_free);
   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;

   assign lead_word = ring_ff[LEAD_TAP];
   assign y = ring_ff[LAG_TAP] ^ (lead_word >> 1) ^ (lead_word[0] ? TWIST : '0);

   always_comb begin
      ring_in      = ring_ff;
      out_value_in = out_value_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (pop) begin
         unique case (head.cmd.mode)
            MODE_SEED: begin
               for (int k = 0; k < WORDS; k++) begin
                  ring_in[k] = ring_start_word(k) ^ head.cmd.seed;
               end
            end
            MODE_NEXT: begin
               // rotate by one slot; y lands in the lead tap
               for (int k = 0; k < WORDS - 1; k++) begin
                  ring_in[k] = ring_ff[k+1];
               end
               ring_in[WORDS-1]  = ring_ff[0];
               ring_in[LEAD_TAP] = y;
               out_value_in      = temper(y);
               out_valid_in      = 1'b1;
            end
            default: begin
               ring_in = ring_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WORDS; k++) begin
            ring_ff[k] <= ring_start_word(k);
         end
         out_valid_ff <= 1'b0;
      end else begin
         ring_ff      <= ring_in;
         out_valid_ff <= out_valid_in;
      end
      out_value_ff <= out_value_in;
   end

endmodule

// ===== rtl/tgfsr_word_generator_unit.sv =====
// ----------------------------------------------------------------------------
// tgfsr_word_generator_unit
// twisted gfsr word generator: 25 words of state, reseed and next commands
// ----------------------------------------------------------------------------
//
//   channel | ports                            | direction | beat
//   --------+----------------------------------+-----------+---------------------
//   req     | req_valid req_stall req_mode     | in        | one command
//           | req_seed                         |           | (reseed or next)
//   rsp     | rsp_valid rsp_stall rsp_value    | out       | one tempered word
//
// - one command per cycle sustained while rsp is not stalled; the state
//   ring steps once per next, so a next can follow a next or a reseed at once
// - an accepted req beat passes through the input register, the command
//   queue and the result register on its way to its rsp beat
// - a reseed beat gives no rsp beat
// - reset is synchronous; it empties front, queue and result register and
//   loads the ring with the fixed table (seed zero)
// - a stalled rsp holds back a next at the queue head; reseeds there drain
//   and the front takes beats until two-entry queue and input register fill
//
module tgfsr_word_generator_unit import tgfsr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic [WORD_BITS-1:0] req_seed,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_value
);

   // front to queue
   logic     push;
   cmd_type  push_cmd;
   logic     q_full;
   // queue to back end
   head_type head;
   logic     pop;

   // front: registers the request beat and decodes its mode
   tgfsr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_seed  (req_seed),
      .q_full    (q_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // decoupling queue so either side can stall alone
   tgfsr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_full   (q_full),
      .head     (head)
   );

   // back end: state ring, twist, temper, result register
   tgfsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value)
   );

endmodule

// ===== rtl/tgfsr_checker.sv =====
// ----------------------------------------------------------------------------
// tgfsr_checker
// port-level checks of the tgfsr word generator, bound to the top level
// ----------------------------------------------------------------------------
module tgfsr_checker import tgfsr_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_mode,
   input logic [WORD_BITS-1:0] req_seed,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [WORD_BITS-1:0] rsp_value
);

   // a stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_mode) && $stable(req_seed))
      else $error("req beat changed while stalled");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("rsp beat changed while stalled");

   // reset leaves no result pending
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // reset leaves the front empty and ready
   a_reset_req: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("req_stall after reset");

   a_rsp_latency: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset) && !$past(reset, 2))
      else $error("rsp beat too soon after reset");

endmodule

bind tgfsr_word_generator_unit tgfsr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_mode  (req_mode),
   .req_seed  (req_seed),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_value (rsp_value)
);
